[hdl/dedf_pkg.sv]
// Shared constants and types for the depth edge darkening filter.
package dedf_pkg;

   localparam int MAX_HEIGHT = 4096;
   localparam int DEF_MAX_WIDTH = 2048;
   localparam int DEF_FRAC_BITS = 16;
   localparam int Q16_ONE = 65536;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 17;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EDGES_ENABLED = 3'd0,
      CSR_FRAME_WIDTH   = 3'd1,
      CSR_FRAME_HEIGHT  = 3'd2,
      CSR_REL_THRESHOLD = 3'd3,
      CSR_DARKEN_AMOUNT = 3'd4
   } csr_index_type;

   // depth line store entry: background flag above the Q16.16 depth
   typedef struct packed {
      logic        bg;
      logic [31:0] depth;
   } depth_entry_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

endpackage

[hdl/depth_edge_darkening_filter.sv]
// Depth edge darkening filter: pixels arrive in raster order and each result
// leaves one row later, so a pixel of row r >= 1 at column c yields the result
// for row r-1, column c; first-row pixels yield nothing. After the last pixel
// of a frame the block drains: each flush transaction returns one pixel of the
// final row, the last one with tlast set. The block works on one transaction
// at a time. An accepted pixel first goes through the line store read; a
// first-row pixel then returns to idle. Any other pixel, and each flush while
// draining, then passes the two colour factor steps and the output load; a
// result still waiting in the result register holds the block in its output
// state. An interior, non-background pixel with edges enabled also takes a
// setup and a threshold step plus up to two passes of the shared bit-serial
// divider, one for the relative depth (skipped on a hard edge or a zero centre
// depth) and one for the edge strength (skipped at or below threshold), each
// producing NUM_W quotient bits, NUM_W being the larger of FRAC_BITS+16 and 34.
// Dropped transactions are taken and discarded without a result. The line
// stores are not cleared after reset; they are written as the first rows
// stream in.
module depth_edge_darkening_filter
   import dedf_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] depth, [39:32] red_in, [47:40] green_in, [55:48] blue_in
   input  logic [55:0]           req_tdata,
   // [0] kind, [1] is_background
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [40:24] edge_weight
   output logic [47:0]           rsp_tdata,
   output logic                  rsp_tlast,  // last_of_frame
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WCW = CW + 1;
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int NUM_W = (FRAC_BITS + 16 > 34) ? FRAC_BITS + 16 : 34;
   localparam logic [32:0] DEPTH_ONE = 33'(1) << FRAC_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_PREP, S_DIV1, S_THRESH, S_DIV2, S_FAC1, S_FAC2, S_EMIT
   } state_type;

   // configuration registers
   logic        edges_enabled_ff;
   logic [11:0] frame_width_ff;
   logic [12:0] frame_height_ff;
   logic [15:0] rel_threshold_ff;
   logic [16:0] darken_amount_ff;

   state_type       state_ff;
   logic [CW-1:0]   col_ff;
   logic [RW-1:0]   row_ff;
   logic            drain_ff;
   depth_entry_type left_ff;
   depth_entry_type newd_ff;
   color_type       rgb_ff;
   logic            is_drain_ff, last_ff;
   logic [FRAC_BITS-1:0] maxd_ff;
   logic            full_ff, dzero_ff;
   logic [31:0]     ad_ff;
   logic [NUM_W-1:0] rel_ff;
   logic [16:0]     s_ff;
   logic [33:0]     prod_ff;
   logic [16:0]     factor_ff;
   logic            rsp_valid_ff, rsp_last_ff;
   logic [47:0]     rsp_data_ff;

   // line store interface
   depth_entry_type above_rd, center_rd, center_next_rd;
   color_type       color_rd;
   logic            mem_wr;

   // divider interface
   logic             div_start, div_done;
   logic [NUM_W-1:0] div_num, div_quo;
   logic [31:0]      div_den;

   // clamped frame size
   logic [WCW-1:0] width_c;
   logic [12:0]    height_c;
   logic           row_end, frame_end;

   logic [15:0] th;
   logic [16:0] df;
   logic        req_acc, load_out;

   // neighbor evaluation
   depth_entry_type nb [4];
   logic [32:0]     diff [4];
   logic [32:0]     adiff [4];
   logic [FRAC_BITS-1:0] maxd_c;
   logic            full_c, do_edge;
   logic [32:0]     dctr;
   logic [17:0]     relc;

   always_comb begin
      if (frame_width_ff == 12'd0) begin
         width_c = WCW'(1);
      end else if (int'(frame_width_ff) > MAX_WIDTH) begin
         width_c = WCW'(MAX_WIDTH);
      end else begin
         width_c = WCW'(frame_width_ff);
      end
      if (frame_height_ff == 13'd0) begin
         height_c = 13'd1;
      end else if (int'(frame_height_ff) > MAX_HEIGHT) begin
         height_c = 13'(MAX_HEIGHT);
      end else begin
         height_c = frame_height_ff;
      end
   end

   assign row_end = ({1'b0, col_ff} + WCW'(1)) >= width_c;
   assign frame_end = ({1'b0, row_ff} + 13'd1) >= height_c;
   assign th = (rel_threshold_ff == 16'd0) ? 16'd1 : rel_threshold_ff;
   assign df = (darken_amount_ff > 17'(Q16_ONE)) ? 17'(Q16_ONE) : darken_amount_ff;

   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc = req_tvalid && req_tready;
   assign load_out = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         edges_enabled_ff <= 1'b0;
         frame_width_ff   <= 12'd640;
         frame_height_ff  <= 13'd480;
         rel_threshold_ff <= 16'd3277;
         darken_amount_ff <= 17'd32768;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_EDGES_ENABLED: edges_enabled_ff <= csr_data[0];
            CSR_FRAME_WIDTH:   frame_width_ff   <= csr_data[11:0];
            CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_data[12:0];
            CSR_REL_THRESHOLD: rel_threshold_ff <= csr_data[15:0];
            CSR_DARKEN_AMOUNT: darken_amount_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // largest neighbor difference; background or a full unit marks a hard edge
   always_comb begin
      nb[0] = left_ff;
      nb[1] = center_next_rd;
      nb[2] = above_rd;
      nb[3] = newd_ff;
      dctr = {center_rd.depth[31], center_rd.depth};
      maxd_c = '0;
      full_c = 1'b0;
      for (int k = 0; k < 4; k++) begin
         diff[k] = dctr - {nb[k].depth[31], nb[k].depth};
         adiff[k] = diff[k][32] ? (33'd0 - diff[k]) : diff[k];
         if (nb[k].bg) begin
            full_c = 1'b1;
         end else if (adiff[k] >= DEPTH_ONE) begin
            full_c = 1'b1;
         end else if (adiff[k][FRAC_BITS-1:0] > maxd_c) begin
            maxd_c = adiff[k][FRAC_BITS-1:0];
         end
      end
      do_edge = edges_enabled_ff && !center_rd.bg && (row_ff >= RW'(2)) &&
                ({1'b0, row_ff} < height_c) && (col_ff != '0) && !row_end;
   end

   assign relc = (rel_ff >= NUM_W'(2 * Q16_ONE)) ? 18'(2 * Q16_ONE) : 18'(rel_ff);
   assign mem_wr = (state_ff == S_READ) && !is_drain_ff;

   // start the divider for relative depth, then for edge strength
   always_comb begin
      div_start = 1'b0;
      div_num = '0;
      div_den = ad_ff;
      if (state_ff == S_PREP && !full_ff && !dzero_ff) begin
         div_start = 1'b1;
         div_num = NUM_W'({maxd_ff, 16'd0});
      end else if (state_ff == S_THRESH && rel_ff > NUM_W'(th)) begin
         div_start = 1'b1;
         div_num = NUM_W'({relc - 18'(th), 17'd0});
         div_den = 32'(th);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               // drop a flush while streaming and a pixel while draining
               if (req_acc && (req_tuser[0] == drain_ff)) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               if (is_drain_ff) begin
                  state_ff <= S_FAC1;
                  if (row_end) begin
                     drain_ff <= 1'b0;
                     col_ff   <= '0;
                     row_ff   <= '0;
                  end else begin
                     col_ff <= col_ff + 1'b1;
                  end
               end else begin
                  if (row_ff == '0) begin
                     state_ff <= S_IDLE;
                  end else if (do_edge) begin
                     state_ff <= S_PREP;
                  end else begin
                     state_ff <= S_FAC1;
                  end
                  if (row_end) begin
                     col_ff <= '0;
                     if (frame_end) begin
                        drain_ff <= 1'b1;
                     end else begin
                        row_ff <= row_ff + 1'b1;
                     end
                  end else begin
                     col_ff <= col_ff + 1'b1;
                  end
               end
            end
            S_PREP: state_ff <= div_start ? S_DIV1 : S_THRESH;
            S_DIV1: if (div_done) state_ff <= S_THRESH;
            S_THRESH: state_ff <= div_start ? S_DIV2 : S_FAC1;
            S_DIV2: if (div_done) state_ff <= S_FAC1;
            S_FAC1: state_ff <= S_FAC2;
            S_FAC2: state_ff <= S_EMIT;
            S_EMIT: begin
               if (load_out) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         newd_ff     <= '{bg: req_tuser[1], depth: req_tdata[31:0]};
         rgb_ff      <= '{red: req_tdata[39:32], green: req_tdata[47:40],
                          blue: req_tdata[55:48]};
         is_drain_ff <= drain_ff;
      end
      if (state_ff == S_READ) begin
         s_ff     <= '0;
         rgb_ff   <= color_rd;
         last_ff  <= is_drain_ff && row_end;
         maxd_ff  <= maxd_c;
         full_ff  <= full_c;
         dzero_ff <= (center_rd.depth == 32'd0);
         ad_ff    <= center_rd.depth[31] ? (32'd0 - center_rd.depth) : center_rd.depth;
         if (!is_drain_ff) begin
            left_ff <= center_rd;
         end
      end
      if (state_ff == S_PREP) begin
         rel_ff <= full_ff ? NUM_W'(Q16_ONE) : '0;
      end
      if (state_ff == S_DIV1 && div_done) begin
         rel_ff <= div_quo;
      end
      if (state_ff == S_DIV2 && div_done) begin
         s_ff <= (div_quo > NUM_W'(Q16_ONE)) ? 17'(Q16_ONE) : div_quo[16:0];
      end
      if (state_ff == S_FAC1) begin
         prod_ff <= s_ff * (17'(Q16_ONE) - df);
      end
      if (state_ff == S_FAC2) begin
         factor_ff <= 17'(Q16_ONE) - 17'(prod_ff[33:16]);
      end
      if (load_out) begin
         rsp_data_ff[7:0]   <= 8'(({17'd0, rgb_ff.red}   * {8'd0, factor_ff}) >> 16);
         rsp_data_ff[15:8]  <= 8'(({17'd0, rgb_ff.green} * {8'd0, factor_ff}) >> 16);
         rsp_data_ff[23:16] <= 8'(({17'd0, rgb_ff.blue}  * {8'd0, factor_ff}) >> 16);
         rsp_data_ff[40:24] <= s_ff;
         rsp_data_ff[47:41] <= '0;
         rsp_last_ff        <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   dedf_line_store #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_line_store (
      .clock          (clock),
      .rd_addr        (col_ff),
      .rd_addr_next   (col_ff + 1'b1),
      .wr_en          (mem_wr),
      .wr_addr        (col_ff),
      .wr_above       (center_rd),
      .wr_center      (newd_ff),
      .wr_color       (rgb_ff),
      .above_rd       (above_rd),
      .center_rd      (center_rd),
      .center_next_rd (center_next_rd),
      .color_rd       (color_rd)
   );

   dedf_divider #(
      .NUM_W(NUM_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_num),
      .denom    (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while waiting");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV1 || state_ff == S_DIV2))
      else $error("divider finished outside a wait state");

   a_strength_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[40:24] <= 17'(Q16_ONE)))
      else $error("edge strength above one");

   a_store_write_once: assert property (@(posedge clock) disable iff (reset)
      mem_wr |=> !mem_wr)
      else $error("line store written twice for one pixel");
`endif

endmodule

[hdl/dedf_line_store.sv]
// Line stores: rows above and at the pixel being judged, plus centre-row colour.
module dedf_line_store
   import dedf_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                         clock,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_next,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  depth_entry_type              wr_above,
   input  depth_entry_type              wr_center,
   input  color_type                    wr_color,
   output depth_entry_type              above_rd,
   output depth_entry_type              center_rd,
   output depth_entry_type              center_next_rd,
   output color_type                    color_rd
);

   depth_entry_type above_mem  [MAX_WIDTH];
   depth_entry_type center_mem [MAX_WIDTH];
   color_type       color_mem  [MAX_WIDTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         above_mem[wr_addr]  <= wr_above;
         center_mem[wr_addr] <= wr_center;
         color_mem[wr_addr]  <= wr_color;
      end
      above_rd       <= above_mem[rd_addr];
      center_rd      <= center_mem[rd_addr];
      center_next_rd <= center_mem[rd_addr_next];
      color_rd       <= color_mem[rd_addr];
   end

endmodule

[hdl/dedf_divider.sv]
// Restoring divider, one quotient bit per cycle.
module dedf_divider
   import dedf_pkg::*;
#(
   parameter int NUM_W = 34
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [31:0]      denom,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [32:0]      rem_ff;
   logic [31:0]      den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [32:0]      trial;

   assign trial = {rem_ff[31:0], quo_ff[NUM_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else if (busy_ff) begin
         // shift one numerator bit into the remainder, subtract if it fits
         if (trial >= {1'b0, den_ff}) begin
            rem_ff <= trial - {1'b0, den_ff};
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule
